// ----- rtl/core/bitmap_slot_allocator_defines.svh -----
// Assertion macros for the bitmap slot allocator.
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_slot_allocator: check failed");
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_slot_allocator: check failed");
`else
`define BSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/bsa_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package bsa_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 4096;
    localparam int unsigned WORD_BITS_DEF = 32;

    localparam int CNT_W  = 12;
    localparam int IDX_W  = 12;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CNT_W-1:0] MAX_IN_USE_RST = 12'hFFF;

    typedef struct packed {
        logic              clear_step;
        logic              accept;
        logic              scan_next;
        logic              commit_alloc;
        logic              commit_free;
        logic              reject;
        logic [STAT_W-1:0] reject_status;
        logic              push_out;
    } t_dp_cmd;

    typedef struct packed {
        logic word_last;
        logic in_free;
        logic limit_hit;
        logic index_bad;
        logic word_has_free;
        logic bit_set;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/core/bitmap_slot_allocator.sv -----
// Bitmap slot allocator: first-fit allocate and free over a pool of NUM_SLOTS slots,
// tracked as WORD_BITS-bit words in one RAM (power-of-two WORD_BITS). Slot 0 is
// reserved. One transaction is processed at a time. A free is accepted, then its
// word is read and the free is committed or refused. An allocate scans from word 0
// past full words, reading one word per cycle through the RAM read port. A request
// refused at accept (limit reached, bad index) goes straight to the result stage.
// A result waits in the output register while the next transaction is taken; a new
// result is held back only while that register is still stalled. After reset the
// bitmap is cleared by a pass over all NUM_WORDS words (128 at the default size)
// during which input is stalled; max_in_use writes are taken at any time.
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator #(
    parameter int unsigned NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF,
    parameter int unsigned WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [bsa_pkg::IDX_W-1:0]   i_free_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bsa_pkg::STAT_W-1:0]  o_status,
    output logic [bsa_pkg::IDX_W-1:0]   o_slot_index,
    output logic [bsa_pkg::CNT_W-1:0]   o_in_use_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bsa_pkg::CNT_W-1:0]   i_max_in_use
);
    import bsa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    bsa_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_func         (i_func),
        .i_free_index   (i_free_index),
        .i_cfg_valid    (i_cfg_valid),
        .i_max_in_use   (i_max_in_use),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_in_use_count (o_in_use_count)
    );

    assign o_cfg_ready = 1'b1;

    `BSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `BSA_ASSERT_NOW(a_refused_has_no_slot, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_slot_index == '0)
    `BSA_ASSERT_NOW(a_alloc_counted, i_clk, i_rst_n, o_out_valid && (o_status == ST_OK) && (o_slot_index != '0), o_in_use_count != '0)
    `BSA_ASSERT_NOW(a_one_commit, i_clk, i_rst_n, 1'b1, $onehot0({dp_cmd.commit_alloc, dp_cmd.commit_free, dp_cmd.reject, dp_cmd.clear_step}))

endmodule

// ----- rtl/core/bsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/bsa_ctrl.sv -----
// Sequencing state machine for the bitmap slot allocator.
module bsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bsa_pkg::t_dp_stat i_stat,
    output bsa_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import bsa_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_FREE_CHK = 3'd3;
    localparam logic [2:0] S_PUSH     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (i_stat.word_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_stat.in_free) begin
                        if (i_stat.index_bad) begin
                            cmd.reject        = 1'b1;
                            cmd.reject_status = ST_BAD_INDEX;
                            n_state           = S_PUSH;
                        end else begin
                            n_state = S_FREE_CHK;
                        end
                    end else if (i_stat.limit_hit) begin
                        cmd.reject        = 1'b1;
                        cmd.reject_status = ST_FULL;
                        n_state           = S_PUSH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.word_has_free) begin
                    cmd.commit_alloc = 1'b1;
                    n_state          = S_PUSH;
                end else if (i_stat.word_last) begin
                    cmd.reject        = 1'b1;
                    cmd.reject_status = ST_FULL;
                    n_state           = S_PUSH;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FREE_CHK: begin
                if (i_stat.bit_set) begin
                    cmd.commit_free = 1'b1;
                end else begin
                    cmd.reject        = 1'b1;
                    cmd.reject_status = ST_NOT_ALLOC;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    cmd.push_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/core/bsa_dp.sv -----
// Datapath: bitmap RAM, word scan, in-use count, limit register and result registers.
module bsa_dp #(
    parameter int unsigned NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF,
    parameter int unsigned WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsa_pkg::t_dp_cmd            i_cmd,
    output bsa_pkg::t_dp_stat           o_stat,
    input  logic                        i_func,
    input  logic [bsa_pkg::IDX_W-1:0]   i_free_index,
    input  logic                        i_cfg_valid,
    input  logic [bsa_pkg::CNT_W-1:0]   i_max_in_use,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [bsa_pkg::STAT_W-1:0]  o_status,
    output logic [bsa_pkg::IDX_W-1:0]   o_slot_index,
    output logic [bsa_pkg::CNT_W-1:0]   o_in_use_count
);
    import bsa_pkg::*;

    localparam int unsigned NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int SLOT_W      = WORD_ADDR_W + BIT_W;
    localparam int WIDE_W      = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
    localparam int unsigned TAIL = NUM_SLOTS % WORD_BITS;
    localparam logic [WORD_BITS-1:0] TAIL_MASK = (TAIL == 0) ? '0 :
        ~((WORD_BITS'(1) << TAIL) - WORD_BITS'(1));
    localparam logic [WORD_ADDR_W-1:0] LAST_WORD = WORD_ADDR_W'(NUM_WORDS - 1);

    logic [WORD_ADDR_W-1:0] r_word_addr;
    logic [WORD_ADDR_W-1:0] n_word_addr;
    logic [WORD_BITS-1:0]   r_bit_mask;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_max;
    logic [STAT_W-1:0]      r_res_status;
    logic [IDX_W-1:0]       r_res_slot;
    logic                   r_out_valid;
    logic [STAT_W-1:0]      r_out_status;
    logic [IDX_W-1:0]       r_out_slot;
    logic [CNT_W-1:0]       r_out_count;

    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   eff_word;
    logic [WORD_BITS-1:0]   free_onehot;
    logic [BIT_W-1:0]       free_pos;
    logic [SLOT_W-1:0]      slot_wide;
    logic [WIDE_W-1:0]      idx_wide;
    logic [WORD_ADDR_W-1:0] idx_word;
    logic [BIT_W-1:0]       idx_bit;
    logic                   wr_en;
    logic [WORD_BITS-1:0]   wr_data;
    logic                   out_free;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_word_addr),
        .o_rd_data (rd_data)
    );

    // Treat slots past the end of the pool as taken.
    assign eff_word    = rd_data | ((r_word_addr == LAST_WORD) ? TAIL_MASK : '0);
    assign free_onehot = ~eff_word & (eff_word + WORD_BITS'(1));

    always_comb begin
        free_pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (free_onehot[i]) begin
                free_pos = free_pos | BIT_W'(i);
            end
        end
    end

    assign slot_wide = {r_word_addr, free_pos};
    assign idx_wide  = WIDE_W'(i_free_index);
    assign idx_word  = idx_wide[BIT_W +: WORD_ADDR_W];
    assign idx_bit   = i_free_index[BIT_W-1:0];

    always_comb begin
        n_word_addr = r_word_addr;
        if (i_cmd.accept) begin
            n_word_addr = (i_func == FUNC_FREE) ? idx_word : '0;
        end else if (i_cmd.scan_next || i_cmd.clear_step) begin
            n_word_addr = r_word_addr + WORD_ADDR_W'(1);
        end
    end

    assign wr_en = i_cmd.clear_step | i_cmd.commit_alloc | i_cmd.commit_free;

    always_comb begin
        if (i_cmd.clear_step) begin
            wr_data = (r_word_addr == '0) ? WORD_BITS'(1) : '0;
        end else if (i_cmd.commit_alloc) begin
            wr_data = rd_data | free_onehot;
        end else begin
            wr_data = rd_data & ~r_bit_mask;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_addr <= '0;
            r_count     <= '0;
            r_max       <= MAX_IN_USE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_word_addr <= n_word_addr;
            if (i_cfg_valid) begin
                r_max <= i_max_in_use;
            end
            if (i_cmd.commit_alloc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.commit_free && r_count != '0) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.push_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bit_mask <= WORD_BITS'(1) << idx_bit;
        end
        if (i_cmd.commit_alloc) begin
            r_res_status <= ST_OK;
            r_res_slot   <= IDX_W'(slot_wide);
        end else if (i_cmd.commit_free) begin
            r_res_status <= ST_OK;
            r_res_slot   <= '0;
        end else if (i_cmd.reject) begin
            r_res_status <= i_cmd.reject_status;
            r_res_slot   <= '0;
        end
        if (i_cmd.push_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.word_last     = (r_word_addr == LAST_WORD);
    assign o_stat.in_free       = (i_func == FUNC_FREE);
    assign o_stat.limit_hit     = (r_count >= r_max);
    assign o_stat.index_bad     = (i_free_index == '0) || (32'(i_free_index) >= NUM_SLOTS);
    assign o_stat.word_has_free = ~&eff_word;
    assign o_stat.bit_set       = |(rd_data & r_bit_mask);
    assign o_stat.out_free      = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_index   = r_out_slot;
    assign o_in_use_count = r_out_count;

endmodule
